// File: hdl/hns_pkg.sv
`default_nettype none

package hns_pkg;

    localparam int GRID_W      = 7;
    localparam int HEIGHT_W    = 16;
    localparam int SPACE_W     = 16;
    localparam int NORM_W      = 16;
    localparam int NZ_W        = 15;
    localparam int DIFF_W      = 17;
    localparam int MAX_CELLS_D = 64;
    localparam int CFG_IDX_W   = 2;

    localparam logic [NZ_W-1:0] UNIT_Q14 = 15'd16384;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SX   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SY   = 2'd2;

    localparam logic [GRID_W-1:0]  GRID_RST = 7'd64;
    localparam logic [SPACE_W-1:0] SPACE_RST = 16'd256;

    typedef struct packed {
        logic                     start;
        logic signed [DIFF_W-1:0] dhx;
        logic signed [DIFF_W-1:0] dhy;
        logic [SPACE_W-1:0]       sx;
        logic [SPACE_W-1:0]       sy;
    } norm_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [NORM_W-1:0] nx;
        logic signed [NORM_W-1:0] ny;
        logic [NZ_W-1:0]          nz;
    } norm_rsp_t;

endpackage

`default_nettype wire

// File: hdl/heightfield_normal_stencil_top.sv
// channel | dir | handshake            | payload
// in      | in  | in_valid/in_ready    | height
// out     | out | out_valid/out_ready  | col, row, norm_x, norm_y, norm_z, frame_end
// cfg     | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// an item that yields no normal only updates the line buffer, a border item yields a
// flat normal and an interior item waits for hns_norm: the shared 32x32 multiplier
// runs 3 products, up to 18 shift steps, 3 squares and 15 two-product trial steps
// per component in hns_norm; a last-row item adds one more result
// line buffer accesses go through one ram port pair, three reads and one write per item
// in_ready is low from acceptance until the item ends and any result of it is taken
// reset sets state, counters and config; line buffer is undefined until written
`default_nettype none

module heightfield_normal_stencil_top #(
    parameter int MAX_CELLS = hns_pkg::MAX_CELLS_D
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic signed [hns_pkg::HEIGHT_W-1:0]   height,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [hns_pkg::GRID_W-1:0]                 col,
    output logic [hns_pkg::GRID_W-1:0]                 row,
    output logic signed [hns_pkg::NORM_W-1:0]          norm_x,
    output logic signed [hns_pkg::NORM_W-1:0]          norm_y,
    output logic [hns_pkg::NZ_W-1:0]                   norm_z,
    output logic                                       frame_end,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [hns_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [hns_pkg::SPACE_W-1:0]           cfg_data
);

    localparam int DEPTH  = MAX_CELLS + 1;
    localparam int AW     = $clog2(DEPTH);
    localparam int GW     = hns_pkg::GRID_W;
    localparam int HW     = hns_pkg::HEIGHT_W;

    localparam logic [2:0] T_IDLE = 3'd0;
    localparam logic [2:0] T_RD0  = 3'd1;
    localparam logic [2:0] T_RD1  = 3'd2;
    localparam logic [2:0] T_RD2  = 3'd3;
    localparam logic [2:0] T_RD3  = 3'd4;
    localparam logic [2:0] T_NORM = 3'd5;
    localparam logic [2:0] T_OUT1 = 3'd6;
    localparam logic [2:0] T_OUT2 = 3'd7;

    logic [2:0]    state_reg;
    logic [GW-1:0] grid_reg;
    logic [15:0]   sx_reg;
    logic [15:0]   sy_reg;
    logic [GW-1:0] col_cnt_reg;
    logic [GW-1:0] row_cnt_reg;
    logic [GW-1:0] x_reg;
    logic [GW-1:0] y_reg;
    logic [HW-1:0] h_reg;
    logic [HW-1:0] left_reg;
    logic [HW-1:0] right_reg;

    logic [GW-1:0] col_reg;
    logic [GW-1:0] row_reg;
    logic [15:0]   nx_reg;
    logic [15:0]   ny_reg;
    logic [hns_pkg::NZ_W-1:0] nz_reg;
    logic          fe_reg;

    logic [GW-1:0] n_use;
    logic [GW-1:0] x_in;
    logic [GW-1:0] y_in;
    logic          interior;
    logic          in_acc;
    logic          out_acc;
    logic          cfg_acc;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;
    logic [GW-1:0] rd_x;

    hns_pkg::norm_req_t nreq;
    hns_pkg::norm_rsp_t nrsp;

    always_comb
    begin
        if (grid_reg == '0)
        begin
            n_use = GW'(1);
        end
        else if (int'(grid_reg) > MAX_CELLS)
        begin
            n_use = GW'(MAX_CELLS);
        end
        else
        begin
            n_use = grid_reg;
        end
    end

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;
    assign cfg_acc = cfg_valid && cfg_ready;

    assign x_in = (col_cnt_reg > n_use || row_cnt_reg > n_use) ? '0 : col_cnt_reg;
    assign y_in = (col_cnt_reg > n_use || row_cnt_reg > n_use) ? '0 : row_cnt_reg;

    assign interior = (x_reg != '0) && (x_reg < n_use) && (y_reg >= GW'(2));

    always_comb
    begin
        unique case (state_reg)
            T_RD0:   rd_x = (x_reg == '0) ? '0 : x_reg - GW'(1);
            T_RD1:   rd_x = x_reg + GW'(1);
            default: rd_x = x_reg;
        endcase
    end

    assign ram_raddr = AW'(rd_x);
    assign ram_waddr = AW'(x_reg);
    assign ram_we    = (state_reg == T_RD3);
    assign ram_wdata = {ram_rdata[15:0], h_reg};

    hns_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign nreq.start = (state_reg == T_RD3) && (y_reg != '0) && interior;
    assign nreq.dhx   = 17'($signed(right_reg)) - 17'($signed(left_reg));
    assign nreq.dhy   = 17'($signed(h_reg)) - 17'($signed(ram_rdata[31:16]));
    assign nreq.sx    = sx_reg;
    assign nreq.sy    = sy_reg;

    hns_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (nreq),
        .rsp   (nrsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= T_IDLE;
            grid_reg    <= hns_pkg::GRID_RST;
            sx_reg      <= hns_pkg::SPACE_RST;
            sy_reg      <= hns_pkg::SPACE_RST;
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_acc)
            begin
                unique case (cfg_index)
                    hns_pkg::CFG_GRID:
                    begin
                        grid_reg    <= cfg_data[GW-1:0];
                        col_cnt_reg <= '0;
                        row_cnt_reg <= '0;
                    end
                    hns_pkg::CFG_SX: sx_reg <= cfg_data;
                    hns_pkg::CFG_SY: sy_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            unique case (state_reg)
                T_IDLE:
                begin
                    if (in_acc)
                    begin
                        x_reg     <= x_in;
                        y_reg     <= y_in;
                        h_reg     <= height;
                        state_reg <= T_RD0;
                    end
                end
                T_RD0:
                begin
                    state_reg <= T_RD1;
                end
                T_RD1:
                begin
                    left_reg  <= ram_rdata[31:16];
                    state_reg <= T_RD2;
                end
                T_RD2:
                begin
                    right_reg <= ram_rdata[15:0];
                    state_reg <= T_RD3;
                end
                T_RD3:
                begin
                    if (x_reg >= n_use)
                    begin
                        col_cnt_reg <= '0;
                        row_cnt_reg <= (y_reg >= n_use) ? '0 : y_reg + GW'(1);
                    end
                    else
                    begin
                        col_cnt_reg <= x_reg + GW'(1);
                        row_cnt_reg <= y_reg;
                    end
                    col_reg <= x_reg;
                    row_reg <= y_reg - GW'(1);
                    fe_reg  <= 1'b0;
                    nx_reg  <= '0;
                    ny_reg  <= '0;
                    nz_reg  <= hns_pkg::UNIT_Q14;
                    if (y_reg == '0)
                    begin
                        state_reg <= T_IDLE;
                    end
                    else if (interior)
                    begin
                        state_reg <= T_NORM;
                    end
                    else
                    begin
                        state_reg <= T_OUT1;
                    end
                end
                T_NORM:
                begin
                    if (nrsp.done)
                    begin
                        nx_reg    <= nrsp.nx;
                        ny_reg    <= nrsp.ny;
                        nz_reg    <= nrsp.nz;
                        state_reg <= T_OUT1;
                    end
                end
                T_OUT1:
                begin
                    if (out_acc)
                    begin
                        if (y_reg == n_use)
                        begin
                            col_reg   <= x_reg;
                            row_reg   <= y_reg;
                            nx_reg    <= '0;
                            ny_reg    <= '0;
                            nz_reg    <= hns_pkg::UNIT_Q14;
                            fe_reg    <= (x_reg == n_use);
                            state_reg <= T_OUT2;
                        end
                        else
                        begin
                            state_reg <= T_IDLE;
                        end
                    end
                end
                T_OUT2:
                begin
                    if (out_acc)
                    begin
                        state_reg <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == T_IDLE);
    assign out_valid = (state_reg == T_OUT1) || (state_reg == T_OUT2);
    assign cfg_ready = 1'b1;
    assign col       = col_reg;
    assign row       = row_reg;
    assign norm_x    = $signed(nx_reg);
    assign norm_y    = $signed(ny_reg);
    assign norm_z    = nz_reg;
    assign frame_end = fe_reg;

endmodule

`default_nettype wire

// File: hdl/hns_ram.sv
`default_nettype none

module hns_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hdl/hns_norm.sv
`default_nettype none

module hns_norm (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire hns_pkg::norm_req_t req,
    output hns_pkg::norm_rsp_t    rsp
);

    localparam logic [3:0] N_IDLE  = 4'd0;
    localparam logic [3:0] N_MX    = 4'd1;
    localparam logic [3:0] N_MY    = 4'd2;
    localparam logic [3:0] N_MZ    = 4'd3;
    localparam logic [3:0] N_ZLD   = 4'd4;
    localparam logic [3:0] N_SHIFT = 4'd5;
    localparam logic [3:0] N_SQ0   = 4'd6;
    localparam logic [3:0] N_SQ1   = 4'd7;
    localparam logic [3:0] N_SQ2   = 4'd8;
    localparam logic [3:0] N_SQ3   = 4'd9;
    localparam logic [3:0] N_CA    = 4'd10;
    localparam logic [3:0] N_CAS   = 4'd11;
    localparam logic [3:0] N_CD1   = 4'd12;
    localparam logic [3:0] N_CD2   = 4'd13;
    localparam logic [3:0] N_CD3   = 4'd14;

    localparam int NZ_W = hns_pkg::NZ_W;
    localparam logic [NZ_W-1:0] UNIT_CMP = hns_pkg::UNIT_Q14;

    logic [3:0]  state_reg;
    logic [15:0] mag_x_reg;
    logic [15:0] mag_y_reg;
    logic        pos_x_reg;
    logic        pos_y_reg;
    logic [15:0] sx_reg;
    logic [15:0] sy_reg;
    logic [32:0] ax_reg;
    logic [32:0] ay_reg;
    logic [32:0] az_reg;
    logic [31:0] s_reg;
    logic [29:0] asq_reg;
    logic [NZ_W-1:0] q_reg;
    logic [3:0]  bit_reg;
    logic [1:0]  comp_reg;
    logic [63:0] p_reg;
    logic [NZ_W-1:0] qx_reg;
    logic [NZ_W-1:0] qy_reg;
    logic [NZ_W-1:0] qz_reg;
    logic        done_reg;

    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [14:0] a_sel;
    logic [NZ_W-1:0] t_val;
    logic [15:0] d_val;
    logic        need_shift;
    logic        take;
    logic [31:0] s_sum;
    logic [16:0] dhx_mag;
    logic [16:0] dhy_mag;
    logic [15:0] qx16;
    logic [15:0] qy16;

    assign dhx_mag = req.dhx[16] ? 17'(-req.dhx) : 17'(req.dhx);
    assign dhy_mag = req.dhy[16] ? 17'(-req.dhy) : 17'(req.dhy);

    always_comb
    begin
        case (comp_reg)
            2'd0:    a_sel = ax_reg[14:0];
            2'd1:    a_sel = ay_reg[14:0];
            default: a_sel = az_reg[14:0];
        endcase
    end

    assign t_val = q_reg | (NZ_W'(1) << bit_reg);
    assign d_val = {t_val, 1'b0} - 16'd1;
    assign need_shift = (|ax_reg[32:15]) | (|ay_reg[32:15]) | (|az_reg[32:15]);
    assign take = (t_val <= UNIT_CMP) && (p_reg <= {4'd0, asq_reg, 30'd0});
    assign s_sum = s_reg + p_reg[31:0];

    always_comb
    begin
        op_a = 32'd0;
        op_b = 32'd0;
        unique case (state_reg)
            N_MX:
            begin
                op_a = {16'd0, sy_reg};
                op_b = {16'd0, mag_x_reg};
            end
            N_MY:
            begin
                op_a = {16'd0, sx_reg};
                op_b = {16'd0, mag_y_reg};
            end
            N_MZ:
            begin
                op_a = {16'd0, sx_reg};
                op_b = {16'd0, sy_reg};
            end
            N_SQ0:
            begin
                op_a = {17'd0, ax_reg[14:0]};
                op_b = {17'd0, ax_reg[14:0]};
            end
            N_SQ1:
            begin
                op_a = {17'd0, ay_reg[14:0]};
                op_b = {17'd0, ay_reg[14:0]};
            end
            N_SQ2:
            begin
                op_a = {17'd0, az_reg[14:0]};
                op_b = {17'd0, az_reg[14:0]};
            end
            N_CA:
            begin
                op_a = {17'd0, a_sel};
                op_b = {17'd0, a_sel};
            end
            N_CD1:
            begin
                op_a = {16'd0, d_val};
                op_b = {16'd0, d_val};
            end
            N_CD2:
            begin
                op_a = p_reg[31:0];
                op_b = s_reg;
            end
            default:
            begin
                op_a = 32'd0;
                op_b = 32'd0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        p_reg <= op_a * op_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                N_IDLE:
                begin
                    if (req.start)
                    begin
                        mag_x_reg <= dhx_mag[15:0];
                        mag_y_reg <= dhy_mag[15:0];
                        pos_x_reg <= !req.dhx[16] && (req.dhx != '0);
                        pos_y_reg <= !req.dhy[16] && (req.dhy != '0);
                        sx_reg    <= req.sx;
                        sy_reg    <= req.sy;
                        state_reg <= N_MX;
                    end
                end
                N_MX:
                begin
                    state_reg <= N_MY;
                end
                N_MY:
                begin
                    ax_reg    <= p_reg[32:0];
                    state_reg <= N_MZ;
                end
                N_MZ:
                begin
                    ay_reg    <= p_reg[32:0];
                    state_reg <= N_ZLD;
                end
                N_ZLD:
                begin
                    az_reg    <= {p_reg[31:0], 1'b0};
                    state_reg <= N_SHIFT;
                end
                N_SHIFT:
                begin
                    if (need_shift)
                    begin
                        ax_reg <= ax_reg >> 1;
                        ay_reg <= ay_reg >> 1;
                        az_reg <= az_reg >> 1;
                    end
                    else
                    begin
                        state_reg <= N_SQ0;
                    end
                end
                N_SQ0:
                begin
                    state_reg <= N_SQ1;
                end
                N_SQ1:
                begin
                    s_reg     <= p_reg[31:0];
                    state_reg <= N_SQ2;
                end
                N_SQ2:
                begin
                    s_reg     <= s_sum;
                    state_reg <= N_SQ3;
                end
                N_SQ3:
                begin
                    s_reg    <= s_sum;
                    comp_reg <= 2'd0;
                    if (s_sum == 32'd0)
                    begin
                        qx_reg    <= '0;
                        qy_reg    <= '0;
                        qz_reg    <= UNIT_CMP;
                        done_reg  <= 1'b1;
                        state_reg <= N_IDLE;
                    end
                    else
                    begin
                        state_reg <= N_CA;
                    end
                end
                N_CA:
                begin
                    q_reg     <= '0;
                    bit_reg   <= 4'd14;
                    state_reg <= N_CAS;
                end
                N_CAS:
                begin
                    asq_reg   <= p_reg[29:0];
                    state_reg <= N_CD1;
                end
                N_CD1:
                begin
                    state_reg <= N_CD2;
                end
                N_CD2:
                begin
                    state_reg <= N_CD3;
                end
                N_CD3:
                begin
                    if (bit_reg == 4'd0)
                    begin
                        case (comp_reg)
                            2'd0:    qx_reg <= take ? t_val : q_reg;
                            2'd1:    qy_reg <= take ? t_val : q_reg;
                            default: qz_reg <= take ? t_val : q_reg;
                        endcase
                        if (comp_reg == 2'd2)
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= N_IDLE;
                        end
                        else
                        begin
                            comp_reg  <= comp_reg + 2'd1;
                            state_reg <= N_CA;
                        end
                    end
                    else
                    begin
                        if (take)
                        begin
                            q_reg <= t_val;
                        end
                        bit_reg   <= bit_reg - 4'd1;
                        state_reg <= N_CD1;
                    end
                end
                default:
                begin
                    state_reg <= N_IDLE;
                end
            endcase
        end
    end

    assign qx16 = {1'b0, qx_reg};
    assign qy16 = {1'b0, qy_reg};

    assign rsp.done = done_reg;
    assign rsp.nx   = $signed(pos_x_reg ? (16'd0 - qx16) : qx16);
    assign rsp.ny   = $signed(pos_y_reg ? (16'd0 - qy16) : qy16);
    assign rsp.nz   = qz_reg;

endmodule

`default_nettype wire

// File: hdl/hns_check.sv
`default_nettype none

module hns_check (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                in_valid,
    input wire logic                                in_ready,
    input wire logic                                out_valid,
    input wire logic                                out_ready,
    input wire logic [hns_pkg::GRID_W-1:0]          col,
    input wire logic [hns_pkg::GRID_W-1:0]          row,
    input wire logic signed [hns_pkg::NORM_W-1:0]   norm_x,
    input wire logic signed [hns_pkg::NORM_W-1:0]   norm_y,
    input wire logic [hns_pkg::NZ_W-1:0]            norm_z,
    input wire logic                                frame_end
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(col) && $stable(row)
        && $stable(norm_x) && $stable(norm_z))
        else $error("result changed while stalled");

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a result is pending");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after an item");

    a_nz_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> norm_z <= hns_pkg::UNIT_Q14)
        else $error("norm_z above one");

    a_fe_corner: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> col == row && norm_z == hns_pkg::UNIT_Q14)
        else $error("frame end off the corner vertex");

endmodule

bind heightfield_normal_stencil_top hns_check u_check (.*);

`default_nettype wire
